FILE: src/dctc_pkg.sv
// ----------------------------------------------------------------------------
// dctc_pkg: shared types and constants of the dual cue toggle controller
// Field widths, configuration register indexes, reset values, item and
// result structs, and the wrapping elapsed-time compare.
// ----------------------------------------------------------------------------
`default_nettype none

package dctc_pkg;

	localparam int unsigned TIME_W    = 32;
	localparam int unsigned SEQ_W     = 32;
	localparam int unsigned MS_W      = 16;
	localparam int unsigned CUES      = 2;
	localparam int unsigned CFG_IDX_W = 3;

	// Item function codes
	localparam logic [1:0] FUNC_POLL   = 2'd0;
	localparam logic [1:0] FUNC_REMOTE = 2'd1;
	localparam logic [1:0] FUNC_LOCAL  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_ARM  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POWER_OFF    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_MASK   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PRIMARY_SEL  = 3'd4;

	// Configuration reset values
	localparam logic [MS_W-1:0] LOCKOUT_RST   = 16'd250;
	localparam logic [MS_W-1:0] ARM_RST       = 16'd50;
	localparam logic [MS_W-1:0] POWER_OFF_RST = 16'd3000;
	localparam logic [1:0]      MASK_RST      = 2'b11;
	localparam logic [1:0]      PSEL_RST      = 2'd0;

	// Primary selection codes and the mask that moves the status lamp to cue 2
	localparam logic [1:0] PSEL_CUE_ONE      = 2'd1;
	localparam logic [1:0] PSEL_CUE_TWO      = 2'd2;
	localparam logic [1:0] MASK_CUE_TWO_ONLY = 2'b10;

	typedef struct packed {
		logic [MS_W-1:0] lockout_ms;
		logic [MS_W-1:0] release_arm_ms;
		logic [MS_W-1:0] poweroff_hold;
		logic [1:0]      local_cue_mask;
		logic [1:0]      primary_cue_select;
	} cfg_t;

	typedef struct packed {
		logic [1:0]        func;
		logic [TIME_W-1:0] now_ms;
		logic [CUES-1:0]   button_low;   // bit0 cue 1, bit1 cue 2
		logic              primary_low;
		logic [CUES-1:0]   edge_mask;
		logic              cue_index;
		logic              new_state;
		logic [SEQ_W-1:0]  remote_seq;
		logic              sync_request;
	} item_t;

	typedef struct packed {
		logic [CUES-1:0]              cue_state;
		logic [CUES-1:0][SEQ_W-1:0]   cue_seq;
		logic [CUES-1:0][TIME_W-1:0]  changed_at;
		logic                         status_led;
		logic [CUES-1:0]              changed_mask;
		logic                         notify_peers;
		logic                         power_off_request;
	} result_t;

	// True when now - start, modulo 2^32, has reached limit
	function automatic logic elapsed_ge(
		input logic [TIME_W-1:0] now,
		input logic [TIME_W-1:0] start,
		input logic [MS_W-1:0]   limit
	);
		logic [TIME_W-1:0] diff;
		diff = now - start;
		return diff >= {{(TIME_W-MS_W){1'b0}}, limit};
	endfunction

endpackage

`default_nettype wire

FILE: src/dctc_cfg_regs.sv
// ----------------------------------------------------------------------------
// dctc_cfg_regs: configuration register file
// Five registers written through a valid/ready channel; always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module dctc_cfg_regs
	import dctc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [MS_W-1:0]      cfg_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lockout_ms         <= LOCKOUT_RST;
			cfg_q.release_arm_ms     <= ARM_RST;
			cfg_q.poweroff_hold      <= POWER_OFF_RST;
			cfg_q.local_cue_mask     <= MASK_RST;
			cfg_q.primary_cue_select <= PSEL_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LOCKOUT: begin
					cfg_q.lockout_ms <= cfg_data;
				end
				REG_RELEASE_ARM: begin
					cfg_q.release_arm_ms <= cfg_data;
				end
				REG_POWER_OFF: begin
					cfg_q.poweroff_hold <= cfg_data;
				end
				REG_LOCAL_MASK: begin
					cfg_q.local_cue_mask <= cfg_data[1:0];
				end
				REG_PRIMARY_SEL: begin
					cfg_q.primary_cue_select <= cfg_data[1:0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: src/dctc_engine.sv
// ----------------------------------------------------------------------------
// dctc_engine: cue state and single-pass item update
// Holds the per-cue and primary-button state, works out the next state and
// the result for the item in the input register, and commits on advance.
// ----------------------------------------------------------------------------
`default_nettype none

module dctc_engine
	import dctc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  advance,
	input  item_t      item,
	input  cfg_t       cfg,
	output result_t    result
);

	// Per-cue state
	logic [CUES-1:0]             color_q,     color_n;
	logic [CUES-1:0][SEQ_W-1:0]  seq_q,       seq_n;
	logic [CUES-1:0][TIME_W-1:0] change_q,    change_n;
	logic [CUES-1:0]             armed_q,     armed_n;
	logic [CUES-1:0]             prev_q,      prev_n;
	logic [CUES-1:0][TIME_W-1:0] rel_start_q, rel_start_n;
	logic [CUES-1:0]             rel_valid_q, rel_valid_n;
	logic [CUES-1:0][TIME_W-1:0] accept_q,    accept_n;

	// Primary button state
	logic              ignore_q,      ignore_n;
	logic [TIME_W-1:0] hold_start_q,  hold_start_n;
	logic              hold_active_q, hold_active_n;
	logic              long_done_q,   long_done_n;

	logic [CUES-1:0] prim_hit;
	logic [CUES-1:0] lock_ok;
	logic [CUES-1:0] rel_ok;
	logic [CUES-1:0] tgl;
	logic [CUES-1:0] chg;
	logic            has_primary;
	logic            held_arm;
	logic            held_poff;
	logic            notify;
	logic            poff;

	always_comb begin
		color_n       = color_q;
		seq_n         = seq_q;
		change_n      = change_q;
		armed_n       = armed_q;
		prev_n        = prev_q;
		rel_start_n   = rel_start_q;
		rel_valid_n   = rel_valid_q;
		accept_n      = accept_q;
		ignore_n      = ignore_q;
		hold_start_n  = hold_start_q;
		hold_active_n = hold_active_q;
		long_done_n   = long_done_q;
		tgl           = '0;
		chg           = '0;
		notify        = 1'b0;
		poff          = 1'b0;

		prim_hit[0] = (cfg.primary_cue_select == PSEL_CUE_ONE);
		prim_hit[1] = (cfg.primary_cue_select == PSEL_CUE_TWO);
		has_primary = |prim_hit;
		held_arm    = elapsed_ge(item.now_ms, hold_start_q, cfg.release_arm_ms);
		held_poff   = elapsed_ge(item.now_ms, hold_start_q, cfg.poweroff_hold);
		for (int c = 0; c < CUES; c++) begin
			lock_ok[c] = elapsed_ge(item.now_ms, accept_q[c], cfg.lockout_ms);
			rel_ok[c]  = elapsed_ge(item.now_ms, rel_start_q[c], cfg.release_arm_ms);
		end

		case (item.func)
			FUNC_POLL: begin
				// Primary button: ignore until first release, tap on release, long hold
				if (has_primary) begin
					if (ignore_q) begin
						if (!item.primary_low) begin
							ignore_n      = 1'b0;
							hold_active_n = 1'b0;
							long_done_n   = 1'b0;
						end
					end else if (item.primary_low) begin
						if (!hold_active_q) begin
							hold_start_n  = item.now_ms;
							hold_active_n = 1'b1;
						end else if (!long_done_q && held_poff) begin
							long_done_n = 1'b1;
							poff        = 1'b1;
						end
					end else begin
						for (int c = 0; c < CUES; c++) begin
							if (prim_hit[c] && cfg.local_cue_mask[c] && hold_active_q &&
							    !long_done_q && held_arm && lock_ok[c]) begin
								tgl[c] = 1'b1;
							end
						end
						hold_active_n = 1'b0;
						long_done_n   = 1'b0;
					end
				end

				// Header buttons: re-arm after release, toggle on armed edge
				for (int c = 0; c < CUES; c++) begin
					if (cfg.local_cue_mask[c] && !prim_hit[c]) begin
						if (item.button_low[c]) begin
							rel_valid_n[c] = 1'b0;
						end else if (prev_q[c]) begin
							rel_start_n[c] = item.now_ms;
							rel_valid_n[c] = 1'b1;
						end else if (rel_valid_q[c] && rel_ok[c]) begin
							armed_n[c]     = 1'b1;
							rel_valid_n[c] = 1'b0;
						end
						prev_n[c] = item.button_low[c];
						if (item.edge_mask[c] && armed_n[c] && item.button_low[c] &&
						    lock_ok[c]) begin
							armed_n[c] = 1'b0;
							tgl[c]     = 1'b1;
						end
					end
				end

				for (int c = 0; c < CUES; c++) begin
					if (tgl[c]) begin
						color_n[c]  = ~color_q[c];
						change_n[c] = item.now_ms;
						seq_n[c]    = seq_q[c] + {{(SEQ_W-1){1'b0}}, 1'b1};
						accept_n[c] = item.now_ms;
						chg[c]      = 1'b1;
						notify      = 1'b1;
					end
				end
			end
			FUNC_REMOTE: begin
				for (int c = 0; c < CUES; c++) begin
					if (item.cue_index == 1'(c)) begin
						if (color_q[c] != item.new_state) begin
							change_n[c] = item.now_ms;
							chg[c]      = 1'b1;
						end
						color_n[c] = item.new_state;
						seq_n[c]   = item.remote_seq;
					end
				end
			end
			FUNC_LOCAL: begin
				for (int c = 0; c < CUES; c++) begin
					if (item.cue_index == 1'(c) && color_q[c] != item.new_state) begin
						change_n[c] = item.now_ms;
						color_n[c]  = item.new_state;
						chg[c]      = 1'b1;
						if (item.sync_request) begin
							seq_n[c] = seq_q[c] + {{(SEQ_W-1){1'b0}}, 1'b1};
							notify   = 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase

		result.cue_state         = color_n;
		result.cue_seq           = seq_n;
		result.changed_at        = change_n;
		result.status_led        = (cfg.local_cue_mask == MASK_CUE_TWO_ONLY) ?
		                           color_n[1] : color_n[0];
		result.changed_mask      = chg;
		result.notify_peers      = notify;
		result.power_off_request = poff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q       <= '0;
			seq_q         <= '0;
			change_q      <= '0;
			armed_q       <= '1;
			prev_q        <= '0;
			rel_start_q   <= '0;
			rel_valid_q   <= '0;
			accept_q      <= '0;
			ignore_q      <= 1'b1;
			hold_start_q  <= '0;
			hold_active_q <= 1'b0;
			long_done_q   <= 1'b0;
		end else if (advance) begin
			color_q       <= color_n;
			seq_q         <= seq_n;
			change_q      <= change_n;
			armed_q       <= armed_n;
			prev_q        <= prev_n;
			rel_start_q   <= rel_start_n;
			rel_valid_q   <= rel_valid_n;
			accept_q      <= accept_n;
			ignore_q      <= ignore_n;
			hold_start_q  <= hold_start_n;
			hold_active_q <= hold_active_n;
			long_done_q   <= long_done_n;
		end
	end

endmodule

`default_nettype wire

FILE: src/dual_cue_button_toggle_controller_core.sv
// ----------------------------------------------------------------------------
// dual_cue_button_toggle_controller_core: dual cue toggle controller
// Two red/green cues driven by debounced header buttons, a primary button
// with tap and long-hold power-off, and remote and local set items.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Direction  Payload
//  -------   ---------------------   ---------  ---------------------------------
//  in        in_valid / in_stall     input      func, now_ms, buttons, edges, set
//  out       out_valid / out_stall   output     cue states, seqs, times, flags
//  cfg       cfg_valid / cfg_ready   input      cfg_index, cfg_data
//
//  One item per cycle sustained while the output does not stall; each input
//  transaction passes the input register, then the result register, with the
//  state update logic sitting between the two registers.
//  Reset clears both stage valids, loads the configuration defaults and puts
//  every cue back to red, sequence zero, armed, with the primary ignored.
//  A stalled result holds; the input register keeps taking transactions as
//  long as it is empty, or the result register is empty or draining in that cycle.
//  The configuration port is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_cue_button_toggle_controller_core
	import dctc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	// Input channel
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           func,
	input  wire logic [TIME_W-1:0]    now_ms,
	input  wire logic                 button_one_low,
	input  wire logic                 button_two_low,
	input  wire logic                 primary_low,
	input  wire logic [1:0]           edge_mask,
	input  wire logic                 cue_index,
	input  wire logic                 new_state,
	input  wire logic [SEQ_W-1:0]     remote_seq,
	input  wire logic                 sync_request,

	// Result channel
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      cue_one_state,
	output logic                      cue_two_state,
	output logic [SEQ_W-1:0]          cue_one_seq,
	output logic [SEQ_W-1:0]          cue_two_seq,
	output logic [TIME_W-1:0]         cue_one_changed_at,
	output logic [TIME_W-1:0]         cue_two_changed_at,
	output logic                      status_led,
	output logic [1:0]                changed_mask,
	output logic                      notify_peers,
	output logic                      power_off_request,

	// Configuration write channel
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [MS_W-1:0]      cfg_data
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_next;
	result_t res_s2;
	logic    valid_s2;

	logic    in_accept;
	logic    s2_free;
	logic    advance;

	// The result register can take a new result when it is empty or its
	// current result leaves this cycle.
	assign s2_free   = !valid_s2 || !out_stall;
	// Move the held item through the update logic into the result register.
	assign advance   = valid_s1 && s2_free;
	// Stall the input only when the input register is full and cannot drain.
	assign in_stall  = valid_s1 && !s2_free;
	assign in_accept = in_valid && !in_stall;

	dctc_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input register: capture the transaction, drop valid once it advances.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1.func         <= func;
			item_s1.now_ms       <= now_ms;
			item_s1.button_low   <= {button_two_low, button_one_low};
			item_s1.primary_low  <= primary_low;
			item_s1.edge_mask    <= edge_mask;
			item_s1.cue_index    <= cue_index;
			item_s1.new_state    <= new_state;
			item_s1.remote_seq   <= remote_seq;
			item_s1.sync_request <= sync_request;
		end
	end

	// State update: commits on advance, so the next item sees the new state.
	dctc_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (res_next)
	);

	// Result register: load on advance, hold while stalled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= advance || (valid_s2 && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid          = valid_s2;
	assign cue_one_state      = res_s2.cue_state[0];
	assign cue_two_state      = res_s2.cue_state[1];
	assign cue_one_seq        = res_s2.cue_seq[0];
	assign cue_two_seq        = res_s2.cue_seq[1];
	assign cue_one_changed_at = res_s2.changed_at[0];
	assign cue_two_changed_at = res_s2.changed_at[1];
	assign status_led         = res_s2.status_led;
	assign changed_mask       = res_s2.changed_mask;
	assign notify_peers       = res_s2.notify_peers;
	assign power_off_request  = res_s2.power_off_request;

endmodule

`default_nettype wire

FILE: src/dctc_checker.sv
// ----------------------------------------------------------------------------
// dctc_checker: port-level assertions for the dual cue toggle controller
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module dctc_checker
	import dctc_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_stall,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic              cue_one_state,
	input wire logic              cue_two_state,
	input wire logic [SEQ_W-1:0]  cue_one_seq,
	input wire logic              status_led,
	input wire logic [1:0]        changed_mask,
	input wire logic              notify_peers
);

	// A stalled result holds its place and its cue one sequence value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cue_one_seq))
		else $error("stalled result changed");

	// With the result register empty the input must not stall.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled while result register empty");

	// A peer notification always comes with a cue change.
	a_notify_change: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && notify_peers |-> changed_mask != 2'b00)
		else $error("notify without cue change");

	// The status lamp mirrors one of the two cues.
	a_status_led: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status_led == cue_one_state || status_led == cue_two_state))
		else $error("status lamp matches neither cue");

endmodule

bind dual_cue_button_toggle_controller_core dctc_checker u_dctc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.cue_one_state (cue_one_state),
	.cue_two_state (cue_two_state),
	.cue_one_seq   (cue_one_seq),
	.status_led    (status_led),
	.changed_mask  (changed_mask),
	.notify_peers  (notify_peers)
);

`default_nettype wire
